>>> hw/rtl/scfla_pkg.sv
// Shared constants, types and size-class arithmetic of the free-list allocator.
`timescale 1ns / 1ps
package scfla_pkg;

    localparam int ADDR_BITS        = 16;
    localparam int LIST_COUNT       = 2048;
    localparam int HEADER_BYTES     = 24;
    localparam int SLOT_COUNT       = 2048;
    localparam int LIST_BITS        = $clog2(LIST_COUNT);
    localparam int SLOT_BITS        = $clog2(SLOT_COUNT);
    localparam int SLOT_SHIFT       = 5;
    localparam int SMALL_SPAN       = 5;
    localparam int MEDIUM_SPAN      = 10;
    localparam int SLACK_BITS       = 3;
    localparam int MEDIUM_EXTRA     = SMALL_SPAN - SLACK_BITS;
    localparam int LARGE_EXTRA      = MEDIUM_SPAN - SLACK_BITS;
    localparam int LIST_ENTRY_SHIFT = 3;
    localparam int MEDIUM_BASE      = (1 << SMALL_SPAN) - (1 << (SMALL_SPAN - MEDIUM_EXTRA));
    localparam int LARGE_BASE       = (1 << SMALL_SPAN) + (1 << MEDIUM_SPAN)
                                      - (1 << (SMALL_SPAN - MEDIUM_EXTRA))
                                      - (1 << (MEDIUM_SPAN - (LARGE_EXTRA - MEDIUM_EXTRA)));
    localparam int HEAP_W           = 17;
    localparam int SHIFT_W          = 4;
    localparam int CALC_W           = 27;
    localparam int BP_W             = ADDR_BITS + 1;
    localparam int CFG_IDX_W        = 2;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_SPACE = 3'd1,
        ST_CORRUPT  = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_SHIFT = CFG_IDX_W'(1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FREE_RD,
        S_PAD,
        S_CLASS,
        S_DISPATCH,
        S_HEAD,
        S_SLOT,
        S_DONE
    } t_state;

    // Header added, rounded up to the granule of the request's range.
    function automatic logic [CALC_W-1:0] pad_calc(input logic [HEAP_W-1:0] b,
                                                   input logic [SHIFT_W-1:0] a);
        logic [CALC_W-1:0] t;
        logic [CALC_W-1:0] m;
        logic [CALC_W-1:0] bx;
        logic [4:0]        s;
        bx = CALC_W'(b);
        t  = bx + CALC_W'(HEADER_BYTES);
        if (bx < (CALC_W'(1) << ({1'b0, a} + 5'(SMALL_SPAN)))) begin
            s = {1'b0, a};
        end else if (bx < (CALC_W'(1) << ({1'b0, a} + 5'(MEDIUM_SPAN)))) begin
            s = {1'b0, a} + 5'(MEDIUM_EXTRA);
        end else begin
            s = {1'b0, a} + 5'(LARGE_EXTRA);
        end
        m = (CALC_W'(1) << s) - CALC_W'(1);
        return (t + m) & ~m;
    endfunction

    function automatic logic [CALC_W-1:0] class_calc(input logic [CALC_W-1:0] p,
                                                     input logic [SHIFT_W-1:0] a);
        logic [CALC_W-1:0] n;
        n = p - CALC_W'(HEADER_BYTES);
        if (n < (CALC_W'(1) << ({1'b0, a} + 5'(SMALL_SPAN)))) begin
            return n >> a;
        end else if (n < (CALC_W'(1) << ({1'b0, a} + 5'(MEDIUM_SPAN)))) begin
            return CALC_W'(MEDIUM_BASE) + (n >> ({1'b0, a} + 5'(MEDIUM_EXTRA)));
        end else begin
            return CALC_W'(LARGE_BASE) + (n >> ({1'b0, a} + 5'(LARGE_EXTRA)));
        end
    endfunction

endpackage

>>> hw/rtl/scfla_if.sv
// Request, response and configuration-write channel interfaces.
`timescale 1ns / 1ps
interface scfla_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] request_bytes;
    logic [15:0] chunk_offset;
    modport source (output valid, operation, request_bytes, chunk_offset, input ready);
    modport sink   (input valid, operation, request_bytes, chunk_offset, output ready);
endinterface

interface scfla_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] offset;
    logic [15:0] chunk_size;
    modport source (output valid, status, offset, chunk_size, input ready);
    modport sink   (input valid, status, offset, chunk_size, output ready);
endinterface

interface scfla_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/size_class_free_list_allocator.sv
// Top level of the segregated free-list heap allocator.
`timescale 1ns / 1ps
// Allocator that serves allocate, free and initialize requests one at a time. List heads
// (with a valid bit) and per-chunk next links and sizes live in two single-port-read
// synchronous memories; each request reads, decides and writes back. An allocate computes
// the class, reads the list head and, if set, its next link; a free reads the chunk's size
// first, then computes the class and pushes the chunk onto its list; a bad operation is
// answered directly. After reset, and on each initialize that empties the lists, a clearing
// pass runs over all 2048 list-head entries; no request is taken meanwhile. The result sits
// in an output register, so the next request is taken while it waits to be collected.
module size_class_free_list_allocator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    scfla_cfg_if.sink    i_cfg,
    scfla_req_if.sink    i_req,
    scfla_rsp_if.source  o_rsp
);
    import scfla_pkg::*;

    logic [ADDR_BITS:0]        r_head_mem [LIST_COUNT];
    logic [2*ADDR_BITS-1:0]    r_slot_mem [SLOT_COUNT];

    t_state                    r_state, n_state;
    logic [HEAP_W-1:0]         r_heap_size;
    logic [SHIFT_W-1:0]        r_align;
    logic [BP_W-1:0]           r_bump, n_bump;
    t_op                       r_op;
    logic [15:0]               r_off;
    logic [HEAP_W-1:0]         r_pin, n_pin;
    logic [CALC_W-1:0]         r_pad, r_cls;
    logic [15:0]               r_head, n_head;
    logic [15:0]               r_size, n_size;
    logic                      r_init, n_init;
    logic [LIST_BITS-1:0]      r_clr, n_clr;
    t_status                   r_res_st, n_res_st;
    logic [15:0]               r_res_off, n_res_off;
    logic [15:0]               r_res_size, n_res_size;
    logic                      r_out_valid;
    t_status                   r_out_st;
    logic [15:0]               r_out_off, r_out_size;

    logic [ADDR_BITS:0]        r_head_q;
    logic [2*ADDR_BITS-1:0]    r_slot_q;

    logic                      head_we;
    logic [LIST_BITS-1:0]      head_wa, head_ra;
    logic [ADDR_BITS:0]        head_wd;
    logic                      next_we, size_we;
    logic [SLOT_BITS-1:0]      slot_wa, slot_ra;
    logic [ADDR_BITS-1:0]      next_wd, size_wd;

    logic [HEAP_W-1:0]         eff;
    logic [CALC_W-1:0]         expect_sz, page, cur, diff, total, u;
    logic                      accept, cls_bad, out_load;

    assign eff       = (r_heap_size > HEAP_W'(1 << ADDR_BITS)) ? HEAP_W'(1 << ADDR_BITS)
                                                               : r_heap_size;
    assign expect_sz = r_pad - CALC_W'(HEADER_BYTES);
    assign total     = r_pad;
    assign u         = CALC_W'(r_bump) + CALC_W'(HEADER_BYTES);
    assign page      = CALC_W'(1) << r_align;
    assign cls_bad   = r_cls >= CALC_W'(LIST_COUNT);
    assign cur       = page - CALC_W'(HEADER_BYTES);
    assign diff      = (r_cls << LIST_ENTRY_SHIFT) - cur + page - CALC_W'(1);

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_st;
    assign o_rsp.offset     = r_out_off;
    assign o_rsp.chunk_size = r_out_size;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == LIST_BITS'(LIST_COUNT - 1)) begin
                    n_state = r_init ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (t_op'(i_req.operation))
                        OP_ALLOC: n_state = S_PAD;
                        OP_FREE:  n_state = (i_req.chunk_offset != '0) ? S_FREE_RD : S_DONE;
                        OP_INIT:  n_state = (r_align < SHIFT_W'(SMALL_SPAN)) ? S_DONE
                                                                              : S_PAD;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_FREE_RD:  n_state = S_PAD;
            S_PAD:      n_state = S_CLASS;
            S_CLASS:    n_state = S_DISPATCH;
            S_DISPATCH: begin
                if (r_op == OP_INIT) begin
                    n_state = S_CLEAR;
                end else begin
                    n_state = cls_bad ? S_DONE : S_HEAD;
                end
            end
            S_HEAD: begin
                if (r_op == OP_ALLOC && r_head_q[ADDR_BITS]
                    && CALC_W'(r_head_q[ADDR_BITS-1:0]) <= CALC_W'(r_bump)) begin
                    n_state = S_SLOT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SLOT:  n_state = S_DONE;
            S_DONE:  n_state = out_load ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_bump     = r_bump;
        n_pin      = r_pin;
        n_head     = r_head;
        n_size     = r_size;
        n_init     = r_init;
        n_clr      = r_clr;
        n_res_st   = r_res_st;
        n_res_off  = r_res_off;
        n_res_size = r_res_size;
        head_we    = 1'b0;
        head_wa    = r_cls[LIST_BITS-1:0];
        head_wd    = '0;
        head_ra    = r_cls[LIST_BITS-1:0];
        next_we    = 1'b0;
        size_we    = 1'b0;
        slot_wa    = r_off[SLOT_SHIFT +: SLOT_BITS];
        slot_ra    = r_off[SLOT_SHIFT +: SLOT_BITS];
        next_wd    = '0;
        size_wd    = '0;
        case (r_state)
            S_CLEAR: begin
                head_we = 1'b1;
                head_wa = r_clr;
                n_clr   = r_clr + LIST_BITS'(1);
                if (r_init && (CALC_W'(r_bump) + page >= CALC_W'(eff))) begin
                    n_res_st = ST_RANGE;
                end
            end
            S_IDLE: begin
                n_res_st   = ST_OK;
                n_res_off  = '0;
                n_res_size = '0;
                n_clr      = '0;
                n_init     = 1'b0;
                slot_ra    = i_req.chunk_offset[SLOT_SHIFT +: SLOT_BITS];
                if (accept) begin
                    case (t_op'(i_req.operation))
                        OP_ALLOC: n_pin = HEAP_W'(i_req.request_bytes);
                        OP_FREE:  ;
                        OP_INIT: begin
                            n_pin = eff;
                            if (r_align < SHIFT_W'(SMALL_SPAN)) begin
                                n_bump   = '0;
                                n_res_st = ST_RANGE;
                            end
                        end
                        default:  n_res_st = ST_RANGE;
                    endcase
                end
            end
            S_FREE_RD: begin
                n_size = r_slot_q[ADDR_BITS-1:0];
                n_pin  = HEAP_W'(r_slot_q[ADDR_BITS-1:0]);
            end
            S_DISPATCH: begin
                if (r_op == OP_INIT) begin
                    n_init = 1'b1;
                    if (cur < (r_cls << LIST_ENTRY_SHIFT)) begin
                        n_bump = BP_W'(cur + (diff & ~(page - CALC_W'(1))));
                    end else begin
                        n_bump = BP_W'(cur);
                    end
                end else if (cls_bad) begin
                    n_res_st = ST_RANGE;
                end
            end
            S_HEAD: begin
                n_head  = r_head_q[ADDR_BITS-1:0];
                slot_ra = r_head_q[SLOT_SHIFT +: SLOT_BITS];
                if (r_op == OP_FREE) begin
                    next_we    = 1'b1;
                    next_wd    = r_head_q[ADDR_BITS] ? r_head_q[ADDR_BITS-1:0] : '0;
                    head_we    = 1'b1;
                    head_wd    = {1'b1, r_off};
                    n_res_size = r_size;
                end else if (r_head_q[ADDR_BITS]) begin
                    if (CALC_W'(r_head_q[ADDR_BITS-1:0]) > CALC_W'(r_bump)) begin
                        n_res_st = ST_CORRUPT;
                    end
                end else if (CALC_W'(r_bump) + total > CALC_W'(eff)) begin
                    n_res_st = ST_NO_SPACE;
                end else begin
                    size_we    = 1'b1;
                    slot_wa    = u[SLOT_SHIFT +: SLOT_BITS];
                    size_wd    = expect_sz[ADDR_BITS-1:0];
                    n_bump     = BP_W'(CALC_W'(r_bump) + total);
                    n_res_off  = u[ADDR_BITS-1:0];
                    n_res_size = expect_sz[ADDR_BITS-1:0];
                end
            end
            S_SLOT: begin
                // Unlink first; a mismatching chunk is dropped
                head_we = 1'b1;
                head_wd = {(r_slot_q[2*ADDR_BITS-1:ADDR_BITS] != '0),
                           r_slot_q[2*ADDR_BITS-1:ADDR_BITS]};
                if (CALC_W'(r_slot_q[ADDR_BITS-1:0]) != expect_sz) begin
                    n_res_st = ST_MISMATCH;
                end else begin
                    n_res_off  = r_head;
                    n_res_size = expect_sz[ADDR_BITS-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head_mem[head_wa] <= head_wd;
        end
        r_head_q <= r_head_mem[head_ra];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_slot_mem[slot_wa][2*ADDR_BITS-1:ADDR_BITS] <= next_wd;
        end
        if (size_we) begin
            r_slot_mem[slot_wa][ADDR_BITS-1:0] <= size_wd;
        end
        r_slot_q <= r_slot_mem[slot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_heap_size <= HEAP_W'(65536);
            r_align     <= SHIFT_W'(6);
            r_bump      <= '0;
            r_init      <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bump  <= n_bump;
            r_init  <= n_init;
            r_clr   <= n_clr;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_HEAP_SIZE) begin
                    r_heap_size <= i_cfg.data;
                end else if (i_cfg.index == REG_ALIGN_SHIFT) begin
                    r_align <= i_cfg.data[SHIFT_W-1:0];
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= t_op'(i_req.operation);
            r_off <= i_req.chunk_offset;
        end
        r_pin      <= n_pin;
        r_head     <= n_head;
        r_size     <= n_size;
        r_res_st   <= n_res_st;
        r_res_off  <= n_res_off;
        r_res_size <= n_res_size;
        if (r_state == S_PAD) begin
            r_pad <= pad_calc(r_pin, r_align);
        end
        if (r_state == S_CLASS) begin
            r_cls <= class_calc(r_pad, r_align);
        end
        if (out_load) begin
            r_out_st   <= r_res_st;
            r_out_off  <= r_res_off;
            r_out_size <= r_res_size;
        end
    end

endmodule
